@@ src/velocity_command_priority_mux_macros.svh @@
// ----------------------------------------------------------------------------
// Velocity command priority mux assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_COMMAND_PRIORITY_MUX_MACROS_SVH
`define VELOCITY_COMMAND_PRIORITY_MUX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle port check failed");

// The consequent must hold in the cycle after the antecedent.
`define VCPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle port check failed");

`endif

@@ src/vcpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command priority mux package
// Request codes, selection codes, register map and shared record types.
// ----------------------------------------------------------------------------
package vcpm_pkg;

  localparam int FIELD_W = 16;
  localparam int LIM_W   = 15;
  localparam int STEP_W  = 22;
  localparam int SEL_W   = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [SEL_W-1:0] SEL_ESTOP   = 3'd4;
  localparam logic [SEL_W-1:0] SEL_TIMEOUT = 3'd5;

  localparam logic [LIM_W-1:0]   RST_MAX_LIN   = 15'd4096;
  localparam logic [LIM_W-1:0]   RST_MAX_ANG   = 15'd8192;
  localparam logic [FIELD_W-1:0] RST_LIN_ACCEL = 16'd4194;
  localparam logic [FIELD_W-1:0] RST_ANG_ACCEL = 16'd8389;
  localparam logic [FIELD_W-1:0] RST_TIMEOUT   = 16'd500;

  typedef enum logic [1:0] {
    REQ_CMD   = 2'd0,
    REQ_ESTOP = 2'd1,
    REQ_TICK  = 2'd2
  } vcpm_req_t;

  typedef enum logic [2:0] {
    REG_MAX_LIN   = 3'd0,
    REG_MAX_ANG   = 3'd1,
    REG_LIN_ACCEL = 3'd2,
    REG_ANG_ACCEL = 3'd3,
    REG_TIMEOUT   = 3'd4
  } vcpm_reg_t;

  typedef struct packed {
    logic [LIM_W-1:0]   max_lin;
    logic [LIM_W-1:0]   max_ang;
    logic [FIELD_W-1:0] lin_accel;
    logic [FIELD_W-1:0] ang_accel;
    logic [FIELD_W-1:0] timeout;
  } vcpm_cfg_t;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] lin_x;
    logic [FIELD_W-1:0] lin_y;
    logic [FIELD_W-1:0] ang_z;
    logic [SEL_W-1:0]   selected;
    logic               estop_state;
    logic               last;
  } vcpm_result_t;

  typedef struct packed {
    logic [1:0]   n;
    vcpm_result_t first;
    vcpm_result_t second;
  } vcpm_push_t;

endpackage

@@ src/vcpm_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command priority mux register file
// Limit, slew and timeout registers behind the configuration port.
// ----------------------------------------------------------------------------
module vcpm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vcpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [vcpm_pkg::DATA_W-1:0]  pwdata,
  output logic [vcpm_pkg::DATA_W-1:0]  prdata,
  output vcpm_pkg::vcpm_cfg_t          cfg
);

  vcpm_pkg::vcpm_cfg_t cfg_r;
  vcpm_pkg::vcpm_reg_t reg_sel;
  logic                wr_en;

  assign reg_sel = vcpm_pkg::vcpm_reg_t'(paddr[vcpm_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_lin   <= vcpm_pkg::RST_MAX_LIN;
      cfg_r.max_ang   <= vcpm_pkg::RST_MAX_ANG;
      cfg_r.lin_accel <= vcpm_pkg::RST_LIN_ACCEL;
      cfg_r.ang_accel <= vcpm_pkg::RST_ANG_ACCEL;
      cfg_r.timeout   <= vcpm_pkg::RST_TIMEOUT;
    end else if (wr_en) begin
      case (reg_sel)
        vcpm_pkg::REG_MAX_LIN:   cfg_r.max_lin   <= pwdata[vcpm_pkg::LIM_W-1:0];
        vcpm_pkg::REG_MAX_ANG:   cfg_r.max_ang   <= pwdata[vcpm_pkg::LIM_W-1:0];
        vcpm_pkg::REG_LIN_ACCEL: cfg_r.lin_accel <= pwdata[vcpm_pkg::FIELD_W-1:0];
        vcpm_pkg::REG_ANG_ACCEL: cfg_r.ang_accel <= pwdata[vcpm_pkg::FIELD_W-1:0];
        vcpm_pkg::REG_TIMEOUT:   cfg_r.timeout   <= pwdata[vcpm_pkg::FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      vcpm_pkg::REG_MAX_LIN:   prdata = vcpm_pkg::DATA_W'(cfg_r.max_lin);
      vcpm_pkg::REG_MAX_ANG:   prdata = vcpm_pkg::DATA_W'(cfg_r.max_ang);
      vcpm_pkg::REG_LIN_ACCEL: prdata = vcpm_pkg::DATA_W'(cfg_r.lin_accel);
      vcpm_pkg::REG_ANG_ACCEL: prdata = vcpm_pkg::DATA_W'(cfg_r.ang_accel);
      vcpm_pkg::REG_TIMEOUT:   prdata = vcpm_pkg::DATA_W'(cfg_r.timeout);
      default:                 prdata = '0;
    endcase
  end

endmodule

@@ src/vcpm_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command priority mux output queue
// Small result queue that takes up to two words per cycle and drains one while out_tready is high.
// ----------------------------------------------------------------------------
module vcpm_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vcpm_pkg::vcpm_push_t         push,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output vcpm_pkg::vcpm_result_t       head,
  output logic [vcpm_pkg::CNT_W-1:0]   free
);

  vcpm_pkg::vcpm_result_t            mem_r [vcpm_pkg::OUT_DEPTH];
  logic [vcpm_pkg::PTR_W-1:0]        wr_ptr_r;
  logic [vcpm_pkg::PTR_W-1:0]        wr_ptr_p1;
  logic [vcpm_pkg::PTR_W-1:0]        rd_ptr_r;
  logic [vcpm_pkg::CNT_W-1:0]        count_r;
  logic                              pop;

  assign pop        = (count_r != '0) && out_tready;
  assign out_tvalid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign free       = vcpm_pkg::CNT_W'(vcpm_pkg::OUT_DEPTH) - count_r;
  assign wr_ptr_p1  = wr_ptr_r + vcpm_pkg::PTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + vcpm_pkg::PTR_W'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + vcpm_pkg::PTR_W'(1);
      end
      count_r <= count_r + vcpm_pkg::CNT_W'(push.n) - vcpm_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

endmodule

@@ src/velocity_command_priority_mux.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command priority mux
// Priority selection of four velocity sources with timeout, limits and slew.
// ----------------------------------------------------------------------------
// The block takes one input word per clock and delivers its results through
// the input register and a four-word output queue. A source command gives no
// output, a tick gives one word, and an emergency stop event gives one word,
// or two when it activates the stop. The slew steps are multiplied while the
// word is captured in the input register, and selection, clamping and slew
// limiting act on the word while it is held there. in_tready stays high while
// the queue has room for the words of the held item, so with out_tready high
// the rate is one word per cycle; each activating emergency stop queues one extra word.
module velocity_command_priority_mux #(
  parameter int NUM_SOURCES = 4,
  parameter int VEL_WIDTH   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: source_index[1:0], cmd_lin_x[17:2], cmd_lin_y[33:18],
  // cmd_ang_z[49:34], estop_value[50], elapsed_ms[66:51], zero fill.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [71:0]                  in_tdata,
  // in_tuser: req_type[1:0].
  input  logic [1:0]                   in_tuser,
  // out_tdata: out_lin_x[15:0], out_lin_y[31:16], out_ang_z[47:32],
  // selected[50:48], estop_state[51], zero fill.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [55:0]                  out_tdata,
  // out_tuser: result_kind[0].
  output logic [0:0]                   out_tuser,
  output logic                         out_tlast,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [vcpm_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [vcpm_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [vcpm_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int SRC_W = $clog2(NUM_SOURCES);
  localparam int DW    = VEL_WIDTH + 1;
  localparam int CW    = (DW > vcpm_pkg::STEP_W) ? DW : vcpm_pkg::STEP_W;
  localparam int LW    = ((VEL_WIDTH > vcpm_pkg::LIM_W) ? VEL_WIDTH : vcpm_pkg::LIM_W) + 1;
  localparam int FW    = vcpm_pkg::FIELD_W;

  typedef logic signed [VEL_WIDTH-1:0] vel_t;

  function automatic vel_t to_vel(input logic [FW-1:0] v);
    return vel_t'(VEL_WIDTH'(v));
  endfunction

  function automatic logic [FW-1:0] to_port(input vel_t v);
    logic [VEL_WIDTH-1:0] u;
    u = v;
    return FW'(u);
  endfunction

  function automatic vel_t clamp_sym(input vel_t v, input logic [vcpm_pkg::LIM_W-1:0] lim);
    logic signed [LW-1:0] l;
    logic signed [LW-1:0] top;
    logic signed [LW-1:0] ve;
    logic signed [LW-1:0] r;
    l   = signed'(LW'(lim));
    top = signed'(LW'((64'd1 << (VEL_WIDTH - 1)) - 64'd1));
    ve  = LW'(v);
    if (l > top) begin
      l = top;
    end
    if (ve > l) begin
      r = l;
    end else if (ve < -l) begin
      r = -l;
    end else begin
      r = ve;
    end
    return vel_t'(r[VEL_WIDTH-1:0]);
  endfunction

  function automatic vel_t slew(input vel_t target, input vel_t last,
                                input logic [vcpm_pkg::STEP_W-1:0] step);
    logic signed [DW-1:0] d;
    logic        [DW-1:0] ad;
    logic signed [DW-1:0] st;
    logic signed [DW-1:0] r;
    d  = DW'(target) - DW'(last);
    ad = d[DW-1] ? DW'(-d) : DW'(d);
    st = signed'(DW'(step));
    if (CW'(ad) <= CW'(step)) begin
      r = DW'(target);
    end else if (d[DW-1]) begin
      r = DW'(last) - st;
    end else begin
      r = DW'(last) + st;
    end
    return vel_t'(r[VEL_WIDTH-1:0]);
  endfunction

  vcpm_pkg::vcpm_cfg_t     cfg;
  vcpm_pkg::vcpm_push_t    push;
  vcpm_pkg::vcpm_result_t  head;
  logic [vcpm_pkg::CNT_W-1:0] free;

  logic [FW-1:0]           elapsed;
  logic [FW-1:0]           dt_in;
  logic [31:0]             lin_prod;
  logic [31:0]             ang_prod;

  logic                    in_valid_r;
  vcpm_pkg::vcpm_req_t     req_r;
  logic [1:0]              src_r;
  vel_t                    in_x_r;
  vel_t                    in_y_r;
  vel_t                    in_z_r;
  logic                    in_estop_r;
  logic [FW-1:0]           dt_r;
  logic [vcpm_pkg::STEP_W-1:0] lin_step_r;
  logic [vcpm_pkg::STEP_W-1:0] ang_step_r;

  vel_t                    cmd_x_r [NUM_SOURCES];
  vel_t                    cmd_y_r [NUM_SOURCES];
  vel_t                    cmd_z_r [NUM_SOURCES];
  logic [NUM_SOURCES-1:0]  valid_r;
  logic [FW-1:0]           age_r   [NUM_SOURCES];
  logic [FW-1:0]           age_nxt [NUM_SOURCES];
  vel_t                    last_x_r;
  vel_t                    last_y_r;
  vel_t                    last_z_r;
  vel_t                    last_x_nxt;
  vel_t                    last_y_nxt;
  vel_t                    last_z_nxt;
  logic                    last_upd;
  logic                    estop_r;

  logic                    src_ok;
  logic [SRC_W-1:0]        src_idx;
  logic                    pick_found;
  logic [SRC_W-1:0]        pick_idx;
  logic [1:0]              need;
  logic                    consume;
  vcpm_pkg::vcpm_result_t  res0;
  vcpm_pkg::vcpm_result_t  res1;

  vcpm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // Input register, with the slew steps computed on the way in.
  assign elapsed  = in_tdata[66:51];
  assign dt_in    = (elapsed == '0) ? FW'(1) : elapsed;
  assign lin_prod = 32'(cfg.lin_accel) * 32'(dt_in);
  assign ang_prod = 32'(cfg.ang_accel) * 32'(dt_in);

  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r      <= vcpm_pkg::vcpm_req_t'(in_tuser);
      src_r      <= in_tdata[1:0];
      in_x_r     <= to_vel(in_tdata[17:2]);
      in_y_r     <= to_vel(in_tdata[33:18]);
      in_z_r     <= to_vel(in_tdata[49:34]);
      in_estop_r <= in_tdata[50];
      dt_r       <= dt_in;
      lin_step_r <= lin_prod[31:10];
      ang_step_r <= ang_prod[31:10];
    end
  end

  // Source ages and priority selection.
  assign src_ok  = (32'(src_r) < NUM_SOURCES);
  assign src_idx = SRC_W'(src_r);

  always_comb begin
    logic [FW:0] sum;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      sum        = {1'b0, age_r[i]} + {1'b0, dt_r};
      age_nxt[i] = sum[FW] ? '1 : sum[FW-1:0];
    end
  end

  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (valid_r[i] && (age_nxt[i] <= cfg.timeout)) begin
        pick_found = 1'b1;
        pick_idx   = SRC_W'(i);
      end
    end
  end

  // Result words for the held item.
  always_comb begin
    res0       = '0;
    res1       = '0;
    need       = 2'd0;
    last_upd   = 1'b0;
    last_x_nxt = '0;
    last_y_nxt = '0;
    last_z_nxt = '0;
    case (req_r)
      vcpm_pkg::REQ_ESTOP: begin
        res0.kind        = 1'b1;
        res0.estop_state = in_estop_r;
        res0.last        = !in_estop_r;
        res1.selected    = vcpm_pkg::SEL_ESTOP;
        res1.estop_state = 1'b1;
        res1.last        = 1'b1;
        need             = in_estop_r ? 2'd2 : 2'd1;
        last_upd         = in_estop_r;
      end
      vcpm_pkg::REQ_TICK: begin
        need          = 2'd1;
        last_upd      = 1'b1;
        res0.last     = 1'b1;
        res0.estop_state = estop_r;
        if (estop_r) begin
          res0.selected = vcpm_pkg::SEL_ESTOP;
        end else if (!pick_found) begin
          res0.selected = vcpm_pkg::SEL_TIMEOUT;
        end else begin
          last_x_nxt    = slew(clamp_sym(cmd_x_r[pick_idx], cfg.max_lin), last_x_r,
                               lin_step_r);
          last_y_nxt    = slew(clamp_sym(cmd_y_r[pick_idx], cfg.max_lin), last_y_r,
                               lin_step_r);
          last_z_nxt    = slew(clamp_sym(cmd_z_r[pick_idx], cfg.max_ang), last_z_r,
                               ang_step_r);
          res0.lin_x    = to_port(last_x_nxt);
          res0.lin_y    = to_port(last_y_nxt);
          res0.ang_z    = to_port(last_z_nxt);
          res0.selected = vcpm_pkg::SEL_W'(pick_idx);
        end
      end
      default: begin
      end
    endcase
  end

  assign consume     = in_valid_r && (vcpm_pkg::CNT_W'(need) <= free);
  assign push.n      = consume ? need : 2'd0;
  assign push.first  = res0;
  assign push.second = res1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      estop_r  <= 1'b0;
      last_x_r <= '0;
      last_y_r <= '0;
      last_z_r <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        age_r[i] <= '0;
      end
    end else if (consume) begin
      if (last_upd) begin
        last_x_r <= last_x_nxt;
        last_y_r <= last_y_nxt;
        last_z_r <= last_z_nxt;
      end
      case (req_r)
        vcpm_pkg::REQ_CMD: begin
          if (src_ok) begin
            valid_r[src_idx] <= 1'b1;
            age_r[src_idx]   <= '0;
          end
        end
        vcpm_pkg::REQ_ESTOP: begin
          estop_r <= in_estop_r;
        end
        vcpm_pkg::REQ_TICK: begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            age_r[i] <= age_nxt[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (consume && (req_r == vcpm_pkg::REQ_CMD) && src_ok) begin
      cmd_x_r[src_idx] <= in_x_r;
      cmd_y_r[src_idx] <= in_y_r;
      cmd_z_r[src_idx] <= in_z_r;
    end
  end

  vcpm_out_fifo u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .head       (head),
    .free       (free)
  );

  assign out_tdata = {4'b0, head.estop_state, head.selected, head.ang_z, head.lin_y,
                      head.lin_x};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

@@ src/vcpm_port_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command priority mux port checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "velocity_command_priority_mux_macros.svh"

module vcpm_port_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [55:0]                  out_tdata,
  input logic [0:0]                   out_tuser,
  input logic                         out_tlast
);

  logic out_hold;
  logic report_word;
  logic estop_word;
  logic estop_ok;

  assign out_hold    = out_tvalid && !out_tready;
  assign report_word = out_tvalid && out_tuser[0];
  assign estop_word  = out_tvalid && !out_tuser[0] &&
                       (out_tdata[50:48] == vcpm_pkg::SEL_ESTOP);
  assign estop_ok    = out_tdata[51] && out_tlast && (out_tdata[47:0] == '0);

  `VCPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_tvalid)
  `VCPM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_hold, $stable(out_tdata) && $stable(out_tlast))
  `VCPM_ASSERT_SAME(a_report_zero, clk, rst_n, report_word, out_tdata[50:0] == '0)
  `VCPM_ASSERT_SAME(a_sel_range, clk, rst_n, out_tvalid, out_tdata[50:48] <= vcpm_pkg::SEL_TIMEOUT)
  `VCPM_ASSERT_SAME(a_estop_stop, clk, rst_n, estop_word, estop_ok)

endmodule

bind velocity_command_priority_mux vcpm_port_checker u_vcpm_port_checker (.*);

@@ verif/tb_velocity_command_priority_mux.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command priority mux testbench
// Sends source commands, ticks and emergency stop events through the input
// stream with random gaps and output stalls. A local model of the mux
// predicts every output word, and each output word is checked in order.
// Register settings change between phases. The phases include the limit
// extremes, a phase with no idling, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_velocity_command_priority_mux;

  localparam int NUM_SRC = 4;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL = 300;

  typedef struct {
    logic [1:0]  req;
    logic [1:0]  src;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] az;
    logic        estop;
    logic [15:0] dt;
  } vel_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [vcpm_pkg::ADDR_W-1:0] cfg_paddr;
  logic [vcpm_pkg::DATA_W-1:0] cfg_pwdata;
  logic [vcpm_pkg::DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  velocity_command_priority_mux dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  vel_req_t               pending_reqs[$];
  vcpm_pkg::vcpm_result_t expected_words[$];
  vel_req_t               drv_req;

  int  src_idle_pct = 29;
  int  sink_idle_pct = 29;
  int  stall_left = 0;
  bit  send_hold = 1'b0;

  int  n_bad = 0;
  int  n_checked = 0;
  int  n_cmds = 0;
  int  n_ticks = 0;
  int  n_estops = 0;
  int  n_settings = 0;

  // Local copy of the mux state and its register settings.
  logic signed [15:0] src_cmd[NUM_SRC][3];
  bit                 src_valid[NUM_SRC];
  int unsigned        src_age[NUM_SRC];
  longint             last_vel[3];
  bit                 estop_on;
  logic [14:0]        lim_lin;
  logic [14:0]        lim_ang;
  logic [15:0]        acc_lin;
  logic [15:0]        acc_ang;
  logic [15:0]        tmo_ms;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic vcpm_pkg::vcpm_result_t pack_word(input logic kind,
                                                       input logic [15:0] x,
                                                       input logic [15:0] y,
                                                       input logic [15:0] z,
                                                       input logic [2:0] sel,
                                                       input logic last);
    vcpm_pkg::vcpm_result_t w;
    w.kind = kind;
    w.lin_x = x;
    w.lin_y = y;
    w.ang_z = z;
    w.selected = sel;
    w.estop_state = estop_on;
    w.last = last;
    return w;
  endfunction

  function automatic longint clamp_vel(input longint v, input longint lim);
    longint l;
    l = (lim > 32767) ? 32767 : lim;
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic longint slew_to(input longint target, input longint prev,
                                     input longint step);
    longint d;
    longint mag;
    d = target - prev;
    mag = (d < 0) ? -d : d;
    if (mag <= step) return target;
    return (d < 0) ? prev - step : prev + step;
  endfunction

  function automatic void stop_word(input logic [2:0] sel);
    last_vel = '{0, 0, 0};
    expected_words.push_back(pack_word(1'b0, 16'd0, 16'd0, 16'd0, sel, 1'b1));
  endfunction

  function automatic void mux_predict(input vel_req_t r);
    int unsigned dt;
    int          pick;
    longint      lstep;
    longint      astep;
    case (r.req)
      vcpm_pkg::REQ_CMD: begin
        n_cmds++;
        src_cmd[r.src][0] = r.lx;
        src_cmd[r.src][1] = r.ly;
        src_cmd[r.src][2] = r.az;
        src_valid[r.src] = 1'b1;
        src_age[r.src] = 0;
      end
      vcpm_pkg::REQ_ESTOP: begin
        n_estops++;
        estop_on = r.estop;
        expected_words.push_back(pack_word(1'b1, 16'd0, 16'd0, 16'd0, 3'd0, !estop_on));
        if (estop_on) begin
          stop_word(vcpm_pkg::SEL_ESTOP);
        end
      end
      vcpm_pkg::REQ_TICK: begin
        n_ticks++;
        dt = (r.dt == 16'd0) ? 1 : r.dt;
        for (int i = 0; i < NUM_SRC; i++) begin
          src_age[i] = (src_age[i] + dt > 65535) ? 65535 : src_age[i] + dt;
        end
        if (estop_on) begin
          stop_word(vcpm_pkg::SEL_ESTOP);
        end else begin
          pick = -1;
          for (int i = NUM_SRC - 1; i >= 0; i--) begin
            if (src_valid[i] && src_age[i] <= tmo_ms) pick = i;
          end
          if (pick < 0) begin
            stop_word(vcpm_pkg::SEL_TIMEOUT);
          end else begin
            lstep = (longint'(acc_lin) * dt) >> 10;
            astep = (longint'(acc_ang) * dt) >> 10;
            last_vel[0] = slew_to(clamp_vel(src_cmd[pick][0], lim_lin), last_vel[0], lstep);
            last_vel[1] = slew_to(clamp_vel(src_cmd[pick][1], lim_lin), last_vel[1], lstep);
            last_vel[2] = slew_to(clamp_vel(src_cmd[pick][2], lim_ang), last_vel[2], astep);
            expected_words.push_back(pack_word(1'b0, 16'(last_vel[0]), 16'(last_vel[1]),
                                               16'(last_vel[2]), 3'(pick), 1'b1));
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_bad(input string what, input vcpm_pkg::vcpm_result_t got,
                            input vcpm_pkg::vcpm_result_t want);
    n_bad++;
    if (n_bad <= 10) begin
      $display("ERROR %s at %0t: got kind=%0d x=%h y=%h z=%h sel=%0d estop=%0d last=%0d",
               what, $time, got.kind, got.lin_x, got.lin_y, got.ang_z, got.selected,
               got.estop_state, got.last);
      $display("      want kind=%0d x=%h y=%h z=%h sel=%0d estop=%0d last=%0d",
               want.kind, want.lin_x, want.lin_y, want.ang_z, want.selected,
               want.estop_state, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        mux_predict(drv_req);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && !send_hold &&
            $urandom_range(99) >= src_idle_pct) begin
          drv_req = pending_reqs.pop_front();
          in_tdata <= {5'd0, drv_req.dt, drv_req.estop, drv_req.az, drv_req.ly,
                       drv_req.lx, drv_req.src};
          in_tuser <= drv_req.req;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    vcpm_pkg::vcpm_result_t got;
    vcpm_pkg::vcpm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser[0];
      got.lin_x = out_tdata[15:0];
      got.lin_y = out_tdata[31:16];
      got.ang_z = out_tdata[47:32];
      got.selected = out_tdata[50:48];
      got.estop_state = out_tdata[51];
      got.last = out_tlast;
      if (expected_words.size() == 0) begin
        report_bad("unexpected output word", got, '0);
      end else begin
        want = expected_words.pop_front();
        n_checked++;
        if (got !== want) report_bad("output word", got, want);
      end
    end
  end

  function automatic void add_req(input logic [1:0] req, input logic [1:0] src,
                                  input logic [15:0] lx, input logic [15:0] ly,
                                  input logic [15:0] az, input logic estop,
                                  input logic [15:0] dt);
    pending_reqs.push_back('{req, src, lx, ly, az, estop, dt});
  endfunction

  function automatic logic [15:0] rand_vel();
    if ($urandom_range(99) < 60) return 16'($urandom());
    return 16'($urandom_range(8191)) - 16'd4096;
  endfunction

  function automatic logic [15:0] rand_dt();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 16'($urandom_range(200));
    if (roll < 90) return 16'($urandom_range(3000));
    return 16'($urandom());
  endfunction

  // Mostly commands and ticks so that sources are kept fresh and age out in
  // turn; emergency stop events and unused request codes are mixed in.
  function automatic void add_random_req();
    int roll;
    roll = $urandom_range(99);
    if (roll < 42) begin
      add_req(vcpm_pkg::REQ_CMD, 2'($urandom_range(3)), rand_vel(), rand_vel(), rand_vel(),
              1'($urandom()), 16'($urandom()));
    end else if (roll < 88) begin
      add_req(vcpm_pkg::REQ_TICK, 2'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 1'($urandom()), rand_dt());
    end else if (roll < 97) begin
      add_req(vcpm_pkg::REQ_ESTOP, 2'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), ($urandom_range(99) < 35), 16'($urandom()));
    end else begin
      add_req(REQ_UNUSED, 2'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 1'($urandom()), 16'($urandom()));
    end
  endfunction

  task automatic cfg_write(input vcpm_pkg::vcpm_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      vcpm_pkg::REG_MAX_LIN:   lim_lin = val[14:0];
      vcpm_pkg::REG_MAX_ANG:   lim_ang = val[14:0];
      vcpm_pkg::REG_LIN_ACCEL: acc_lin = val;
      vcpm_pkg::REG_ANG_ACCEL: acc_ang = val;
      vcpm_pkg::REG_TIMEOUT:   tmo_ms = val;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic [15:0] lin, input logic [15:0] ang,
                            input logic [15:0] lacc, input logic [15:0] aacc,
                            input logic [15:0] tmo);
    cfg_write(vcpm_pkg::REG_MAX_LIN, lin);
    cfg_write(vcpm_pkg::REG_MAX_ANG, ang);
    cfg_write(vcpm_pkg::REG_LIN_ACCEL, lacc);
    cfg_write(vcpm_pkg::REG_ANG_ACCEL, aacc);
    cfg_write(vcpm_pkg::REG_TIMEOUT, tmo);
    n_settings++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int idle_pct, input bit long_stall,
                           input bit drain_pause);
    @(negedge clk);
    src_idle_pct = idle_pct;
    sink_idle_pct = idle_pct;
    repeat (n_items) add_random_req();
    if (long_stall) stall_left = LONG_STALL;
    if (drain_pause) begin
      while (pending_reqs.size() > n_items / 2) @(negedge clk);
      send_hold = 1'b1;
      while (in_tvalid || expected_words.size() != 0) @(negedge clk);
      send_hold = 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int i = 0; i < NUM_SRC; i++) begin
      src_cmd[i] = '{16'sd0, 16'sd0, 16'sd0};
      src_valid[i] = 1'b0;
      src_age[i] = 0;
    end
    last_vel = '{0, 0, 0};
    estop_on = 1'b0;
    lim_lin = vcpm_pkg::RST_MAX_LIN;
    lim_ang = vcpm_pkg::RST_MAX_ANG;
    acc_lin = vcpm_pkg::RST_LIN_ACCEL;
    acc_ang = vcpm_pkg::RST_ANG_ACCEL;
    tmo_ms = vcpm_pkg::RST_TIMEOUT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings.
    @(negedge clk);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_CMD, 2'd3, 16'h7fff, 16'h8000, 16'h1234, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_CMD, 2'd2, 16'h8000, 16'h7fff, 16'h8000, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd400);
    add_req(vcpm_pkg::REQ_CMD, 2'd1, 16'd100, 16'hff9c, 16'd50, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd1);
    add_req(vcpm_pkg::REQ_CMD, 2'd0, 16'h0800, 16'hf800, 16'h7fff, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'hffff);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'hffff);
    add_req(vcpm_pkg::REQ_CMD, 2'd3, 16'h0400, 16'hfc00, 16'hff00, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd10);
    add_req(vcpm_pkg::REQ_ESTOP, 2'd0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd5);
    add_req(vcpm_pkg::REQ_ESTOP, 2'd0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd0);
    add_req(vcpm_pkg::REQ_ESTOP, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd5);
    add_req(REQ_UNUSED, 2'd3, 16'hffff, 16'hffff, 16'hffff, 1'b1, 16'hffff);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd1);
    add_req(vcpm_pkg::REQ_CMD, 2'd0, 16'hffff, 16'hffff, 16'hffff, 1'b0, 16'd0);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd500);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd1);
    add_req(vcpm_pkg::REQ_TICK, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd2);
    wait_idle();

    set_config(16'd32767, 16'd32767, 16'hffff, 16'hffff, 16'hffff);
    run_phase(250, 29, 1'b0, 1'b0);
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(150, 29, 1'b0, 1'b0);
    for (int k = 0; k < 5; k++) begin
      set_config(($urandom_range(99) < 50) ? 16'($urandom_range(500, 8000))
                                           : 16'($urandom_range(32767)),
                 ($urandom_range(99) < 50) ? 16'($urandom_range(500, 12000))
                                           : 16'($urandom_range(32767)),
                 16'($urandom()), 16'($urandom()), 16'($urandom_range(20, 1500)));
      run_phase(260, (k == 1) ? 0 : 29, (k == 2), (k == 3));
    end

    if (expected_words.size() != 0) n_bad += expected_words.size();
    $display("Covered %0d source commands, %0d ticks and %0d emergency stop events",
             n_cmds, n_ticks, n_estops);
    $display("over %0d register settings; %0d output words checked, %0d errors.",
             n_settings + 1, n_checked, n_bad);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d output words still expected.", expected_words.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ velocity_command_priority_mux.f @@
+incdir+src
src/vcpm_pkg.sv
src/vcpm_cfg_regs.sv
src/vcpm_out_fifo.sv
src/velocity_command_priority_mux.sv
src/vcpm_port_checker.sv
verif/tb_velocity_command_priority_mux.sv
